[rtl/midc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Midpoint circle rasterizer package
// Widths, register indexes and stream field layout shared by the RTL.
// ----------------------------------------------------------------------------
package midc_pkg;

    localparam int COORD_BITS = 12;
    localparam int RAD_W      = COORD_BITS - 1;
    localparam int PIX_W      = COORD_BITS + 1;
    localparam int DEC_W      = COORD_BITS + 4;
    localparam int FRAME_W    = 12;
    localparam int CMP_W      = (COORD_BITS > FRAME_W) ? COORD_BITS : FRAME_W;
    localparam int COLOR_W    = 8;

    localparam int CFG_IDX_W  = 2;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    localparam logic MODE_START = 1'b0;
    localparam logic MODE_STEP  = 1'b1;

    localparam int IN_BITS   = 2 * COORD_BITS + RAD_W + 3 * COLOR_W;
    localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS  = 2 * PIX_W + 3 * COLOR_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;
    localparam int OUT_USER_W = 2;

    typedef logic [3*COLOR_W-1:0] t_color;

endpackage
`default_nettype wire

[rtl/midpoint_circle_rasterizer.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Midpoint circle rasterizer
// Bresenham circle generator: each emitting item gives eight symmetric points.
// ----------------------------------------------------------------------------
// The points of an item go from the generator snapshot through the output
// register; the single output port carries one point per cycle unless it stalls.
// A new item is taken only while the generator is idle or as the eighth point
// of the last item loads; a step that emits nothing leaves the generator idle.
// Reset (synchronous, active low) clears the circle state and sets the frame
// to 800 by 800; no reset sweep is needed.
module midpoint_circle_rasterizer (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    // center_x[11:0], center_y[23:12], radius[34:24], red[42:35],
    // green[50:43], blue[58:51], zero fill above
    input  wire  [midc_pkg::IN_DATA_W-1:0]       i_s_tdata,
    // mode
    input  wire                                  i_s_tuser,
    input  wire                                  i_s_tvalid,
    output logic                                 o_s_tready,
    // pixel_x[12:0], pixel_y[25:13], red[33:26], green[41:34], blue[49:42],
    // zero fill above
    output logic [midc_pkg::OUT_DATA_W-1:0]      o_m_tdata,
    // in_frame[0], done_res[1]
    output logic [midc_pkg::OUT_USER_W-1:0]      o_m_tuser,
    output logic                                 o_m_tlast,
    output logic                                 o_m_tvalid,
    input  wire                                  i_m_tready,
    input  wire                                  i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire  [midc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire  [midc_pkg::FRAME_W-1:0]         i_cfg_data
);
    import midc_pkg::*;

    // Configuration
    logic [FRAME_W-1:0] r_width;
    logic [FRAME_W-1:0] r_height;

    // Circle state
    logic [RAD_W-1:0]             r_x, n_x;
    logic [RAD_W-1:0]             r_y, n_y;
    logic signed [DEC_W-1:0]      r_dec, n_dec;
    logic signed [COORD_BITS-1:0] r_cx, n_cx;
    logic signed [COORD_BITS-1:0] r_cy, n_cy;
    t_color                       r_color, n_color;
    logic                         r_active, n_active;
    logic                         n_fin;

    // Point generator
    logic                         r_busy;
    logic [2:0]                   r_idx;
    logic [RAD_W-1:0]             r_ex, r_ey;
    logic signed [COORD_BITS-1:0] r_ecx, r_ecy;
    t_color                       r_ecolor;
    logic                         r_efin;

    // Output register
    logic                         r_out_valid;
    logic signed [PIX_W-1:0]      r_px, r_py;
    t_color                       r_ocolor;
    logic                         r_in_frame, r_last, r_done;

    logic in_accept, emitting, out_load;
    logic [RAD_W-1:0] in_radius;
    logic signed [DEC_W-1:0] x4, y4;
    logic [RAD_W-1:0] off_a, off_b;
    logic signed [PIX_W-1:0] px, py;
    logic in_frame;

    assign o_cfg_ready = 1'b1;
    assign in_radius   = i_s_tdata[2*COORD_BITS +: RAD_W];

    assign out_load   = r_busy && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_busy || (r_idx == 3'd7 && out_load);
    assign in_accept  = i_s_tvalid && o_s_tready;
    assign emitting   = (i_s_tuser == MODE_START) || r_active;

    assign x4 = DEC_W'({r_x, 2'b00});
    assign y4 = DEC_W'({r_y, 2'b00});

    always_comb begin
        n_x      = r_x;
        n_y      = r_y;
        n_dec    = r_dec;
        n_cx     = r_cx;
        n_cy     = r_cy;
        n_color  = r_color;
        if (i_s_tuser == MODE_START) begin
            n_cx    = i_s_tdata[0 +: COORD_BITS];
            n_cy    = i_s_tdata[COORD_BITS +: COORD_BITS];
            n_y     = in_radius;
            n_x     = '0;
            n_dec   = DEC_W'(3) - DEC_W'({in_radius, 1'b0});
            // The color word keeps red in the high byte.
            n_color = {i_s_tdata[2*COORD_BITS+RAD_W +: COLOR_W],
                       i_s_tdata[2*COORD_BITS+RAD_W+COLOR_W +: COLOR_W],
                       i_s_tdata[2*COORD_BITS+RAD_W+2*COLOR_W +: COLOR_W]};
        end else if (r_active) begin
            if (r_dec < 0) begin
                n_dec = r_dec + x4 + DEC_W'(6);
            end else begin
                n_dec = r_dec + (x4 - y4) + DEC_W'(10);
                n_y   = r_y - 1'b1;
            end
            n_x = r_x + 1'b1;
        end
        n_fin    = !(n_x < n_y);
        n_active = emitting ? !n_fin : r_active;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= FRAME_W'(800);
            r_height <= FRAME_W'(800);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_FRAME_WIDTH:  r_width  <= i_cfg_data;
                REG_FRAME_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x      <= '0;
            r_y      <= '0;
            r_dec    <= '0;
            r_cx     <= '0;
            r_cy     <= '0;
            r_color  <= '0;
            r_active <= 1'b0;
        end else if (in_accept) begin
            r_x      <= n_x;
            r_y      <= n_y;
            r_dec    <= n_dec;
            r_cx     <= n_cx;
            r_cy     <= n_cy;
            r_color  <= n_color;
            r_active <= n_active;
        end
    end

    // The generator takes a snapshot of the new state so the next item can
    // update the circle in the same cycle as the eighth point loads the output.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else begin
            if (out_load) begin
                r_idx <= r_idx + 1'b1;
                if (r_idx == 3'd7) begin
                    r_busy <= 1'b0;
                end
            end
            if (in_accept && emitting) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && emitting) begin
            r_ex     <= n_x;
            r_ey     <= n_y;
            r_ecx    <= n_cx;
            r_ecy    <= n_cy;
            r_ecolor <= n_color;
            r_efin   <= n_fin;
        end
    end

    // Point order: the upper index bit swaps x and y, bit 0 negates the
    // column offset and bit 1 negates the row offset.
    assign off_a = r_idx[2] ? r_ey : r_ex;
    assign off_b = r_idx[2] ? r_ex : r_ey;

    always_comb begin
        if (r_idx[0]) begin
            px = PIX_W'(r_ecx) - $signed(PIX_W'(off_a));
        end else begin
            px = PIX_W'(r_ecx) + $signed(PIX_W'(off_a));
        end
        if (r_idx[1]) begin
            py = PIX_W'(r_ecy) - $signed(PIX_W'(off_b));
        end else begin
            py = PIX_W'(r_ecy) + $signed(PIX_W'(off_b));
        end
        in_frame = !px[PIX_W-1] && !py[PIX_W-1] &&
                   (CMP_W'(px[COORD_BITS-1:0]) < CMP_W'(r_width)) &&
                   (CMP_W'(py[COORD_BITS-1:0]) < CMP_W'(r_height));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_px       <= px;
            r_py       <= py;
            r_ocolor   <= r_ecolor;
            r_in_frame <= in_frame;
            r_last     <= (r_idx == 3'd7);
            r_done     <= r_efin;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tlast  = r_last;
    assign o_m_tuser  = {r_done, r_in_frame};
    assign o_m_tdata  = OUT_DATA_W'({r_ocolor[COLOR_W-1:0],
                                     r_ocolor[COLOR_W +: COLOR_W],
                                     r_ocolor[2*COLOR_W +: COLOR_W],
                                     r_py, r_px});

endmodule
`default_nettype wire
